@@ hw/rtl/mmpd_pkg.sv @@
// ----------------------------------------------------------------------------
// mmpd_pkg
// shared types, register indexes and stage records of the multi-mode pd
// controller
// ----------------------------------------------------------------------------
package mmpd_pkg;

  localparam int unsigned SAMPLE_W    = 16;  // position and velocity samples
  localparam int unsigned GAIN_W      = 16;  // signed q8.8 gains
  localparam int unsigned ERR_W       = 18;  // error term
  localparam int unsigned DIFF_W      = 19;  // first difference, aux register
  localparam int unsigned DIFF2_W     = 20;  // second difference
  localparam int unsigned DRIVE_W     = 40;  // drive output, 8 fraction bits
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned PROD_E_W = GAIN_W + ERR_W;
  localparam int unsigned PROD_D_W = GAIN_W + DIFF_W;
  localparam int unsigned PROD_A_W = GAIN_W + DIFF2_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;
  typedef logic signed [ERR_W-1:0]    err_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [DIFF2_W-1:0]  diff2_t;
  typedef logic signed [DRIVE_W-1:0]  drive_t;
  typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  typedef enum logic [1:0] {
    MODE_PD          = 2'd0,
    MODE_EXT_DERIV   = 2'd1,
    MODE_SECOND_DIFF = 2'd2,
    MODE_SIGN_MAG    = 2'd3
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_SETPOINT = 3'd1,
    REG_GAIN_P   = 3'd2,
    REG_GAIN_I   = 3'd3,
    REG_GAIN_D   = 3'd4
  } reg_index_t;

  // error-stage record handed to the multiply stage
  typedef struct packed {
    err_t   e;
    diff_t  d;
    diff2_t a;
  } err_terms_t;

  // gain set seen by the multiply stage
  typedef struct packed {
    gain_t p;
    gain_t i;
    gain_t d;
  } gains_t;

endpackage

@@ hw/rtl/mmpd_error.sv @@
// ----------------------------------------------------------------------------
// mmpd_error
// error, first and second difference stage; holds the previous error and the
// shared auxiliary register
// ----------------------------------------------------------------------------
module mmpd_error (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mmpd_pkg::sample_t   position,
  input  mmpd_pkg::sample_t   velocity,
  input  mmpd_pkg::mode_t     mode,
  input  mmpd_pkg::sample_t   setpoint,
  output logic                terms_valid,
  input  logic                terms_ready,
  output mmpd_pkg::err_terms_t terms
);
  import mmpd_pkg::*;

  err_t       previous_error;
  diff_t      aux_memory;
  logic       accept;
  err_t       pos_w;
  err_t       sp_w;
  err_t       scaled;
  err_t       magnitude;
  err_t       target;
  diff_t      sign_val;
  err_t       e_next;
  diff_t      d_next;
  diff2_t     a_next;

  assign in_stall = terms_valid & ~terms_ready;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    pos_w     = ERR_W'($signed(position));
    sp_w      = ERR_W'($signed(setpoint));
    // zero counts as negative
    sign_val  = ($signed(position) > $signed(SAMPLE_W'(0))) ? DIFF_W'(1) : -DIFF_W'(1);
    // exact doubling at 18 bits when the sign differs from the aux register
    scaled    = (sign_val == aux_memory) ? pos_w : (pos_w <<< 1);
    magnitude = scaled[ERR_W-1] ? -scaled : scaled;
    target    = (mode == MODE_SIGN_MAG) ? magnitude : pos_w;
    if (mode == MODE_EXT_DERIV) begin
      e_next = sp_w - pos_w;
      d_next = DIFF_W'($signed(velocity));
    end else begin
      e_next = target - sp_w;
      d_next = DIFF_W'($signed(e_next)) - DIFF_W'($signed(previous_error));
    end
    if (mode == MODE_SECOND_DIFF) begin
      a_next = DIFF2_W'($signed(d_next)) - DIFF2_W'($signed(aux_memory));
    end else begin
      a_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      aux_memory     <= '0;
      terms_valid    <= 1'b0;
    end else begin
      if (accept) begin
        previous_error <= e_next;
        terms_valid    <= 1'b1;
        if (mode == MODE_SIGN_MAG) begin
          aux_memory <= sign_val;
        end else if (mode == MODE_SECOND_DIFF) begin
          aux_memory <= d_next;
        end
      end else if (terms_ready) begin
        terms_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      terms.e <= e_next;
      terms.d <= d_next;
      terms.a <= a_next;
    end
  end

endmodule

@@ hw/rtl/mmpd_mac.sv @@
// ----------------------------------------------------------------------------
// mmpd_mac
// gain multiply stage followed by the sum stage that holds the drive output
// ----------------------------------------------------------------------------
module mmpd_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 terms_valid,
  output logic                 terms_ready,
  input  mmpd_pkg::err_terms_t terms,
  input  mmpd_pkg::gains_t     gains,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mmpd_pkg::drive_t     drive
);
  import mmpd_pkg::*;

  logic                       prod_valid;
  logic                       prod_ready;
  logic                       out_ready;
  logic signed [PROD_E_W-1:0] prod_e;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [PROD_A_W-1:0] prod_a;

  assign out_ready   = ~out_valid | ~out_stall;
  assign prod_ready  = ~prod_valid | out_ready;
  assign terms_ready = prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid <= terms_valid;
      end
      if (out_ready) begin
        out_valid <= prod_valid;
      end
    end
  end

  // products, one multiplier per term
  always_ff @(posedge clk) begin
    if (prod_ready && terms_valid) begin
      prod_e <= PROD_E_W'($signed(gains.p) * $signed(terms.e));
      prod_d <= PROD_D_W'($signed(gains.d) * $signed(terms.d));
      prod_a <= PROD_A_W'($signed(gains.i) * $signed(terms.a));
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && prod_valid) begin
      drive <= DRIVE_W'(prod_e) + DRIVE_W'(prod_d) + DRIVE_W'(prod_a);
    end
  end

endmodule

@@ hw/rtl/multi_mode_pd_controller.sv @@
// ----------------------------------------------------------------------------
// multi_mode_pd_controller
// four-mode pd position controller, one drive value per position sample
// ----------------------------------------------------------------------------
// usage:
//   - input channel: position and velocity with in_valid / in_stall; a sample
//     transfers at a clock edge with in_valid high and in_stall low
//   - output channel: drive (signed, 8 fraction bits) with out_valid /
//     out_stall; one result per input sample, in order
//   - config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//     cfg_ready is always high; index 0 mode, 1 setpoint, 2 gain_p,
//     3 gain_i, 4 gain_d; other indexes are ignored
//   - the user writes registers only while no sample is in flight; the
//     block itself does not enforce this
//   - a sample passes the error, multiply and sum registers in turn
//   - throughput: one sample per cycle while out_stall is low; the three
//     gain multipliers work side by side in the multiply stage
//   - output stall: the pipeline holds, drive stays stable, and in_stall
//     rises once all three stages are full
//   - reset (rst, synchronous): pipeline empties, previous error and the aux
//     register clear, mode 0, setpoint 0, gain_p 1.0, gain_i and gain_d 0
// ----------------------------------------------------------------------------
module multi_mode_pd_controller (
  input  logic                   clk,
  input  logic                   rst,
  // sample input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  mmpd_pkg::sample_t      position,
  input  mmpd_pkg::sample_t      velocity,
  // drive output
  output logic                   out_valid,
  input  logic                   out_stall,
  output mmpd_pkg::drive_t       drive,
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  mmpd_pkg::cfg_index_t   cfg_index,
  input  mmpd_pkg::cfg_data_t    cfg_data
);
  import mmpd_pkg::*;

  mode_t      mode;
  sample_t    setpoint;
  gains_t     gains;
  logic       terms_valid;
  logic       terms_ready;
  err_terms_t terms;

  // register file is always ready to take a write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_PD;
      setpoint <= '0;
      gains.p  <= GAIN_W'(256);  // 1.0 in q8.8
      gains.i  <= '0;
      gains.d  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:     mode     <= mode_t'(cfg_data[1:0]);
        REG_SETPOINT: setpoint <= sample_t'(cfg_data);
        REG_GAIN_P:   gains.p  <= gain_t'(cfg_data);
        REG_GAIN_I:   gains.i  <= gain_t'(cfg_data);
        REG_GAIN_D:   gains.d  <= gain_t'(cfg_data);
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // error stage: e, d and a plus the controller state
  mmpd_error u_error (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .position    (position),
    .velocity    (velocity),
    .mode        (mode),
    .setpoint    (setpoint),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms)
  );

  // gain multiply and sum, ends in the drive register
  mmpd_mac u_mac (
    .clk         (clk),
    .rst         (rst),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms),
    .gains       (gains),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive       (drive)
  );

endmodule

@@ hw/rtl/mmpd_checker.sv @@
// ----------------------------------------------------------------------------
// mmpd_checker
// port-level checks on the multi-mode pd controller, bound to the top level
// ----------------------------------------------------------------------------
module mmpd_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input mmpd_pkg::drive_t     drive,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);
  import mmpd_pkg::*;

  // reset empties the output register
  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // an empty output means the whole pipeline moves, so input is never stalled
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // a stalled result holds its value
  a_drive_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive))
    else $error("stalled drive changed");

  // the register file never back-pressures
  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind multi_mode_pd_controller mmpd_checker u_mmpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .drive     (drive),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

@@ tb/sv/tb_multi_mode_pd_controller.sv @@
// ----------------------------------------------------------------------------
// tb_multi_mode_pd_controller
// self-checking bench for the four-mode pd position controller: a directed
// table of samples and register writes, then random phases with fresh gains,
// setpoints and modes; every drive value is checked against a hand-typed
// value or a cycle-free model of the control law kept in the bench
// ----------------------------------------------------------------------------
module tb_multi_mode_pd_controller;
  import mmpd_pkg::*;

  localparam int PERIOD      = 8;
  localparam int RESET_TICKS = 6;
  localparam int ITEM_TARGET = 525;      // random samples after the table
  localparam int LONG_HOLD   = 64;       // receiver hold-off, in cycles
  localparam int TAIL_CYCLES = 12;       // pipeline is 3 deep
  localparam int CYCLE_LIMIT = 200000;

  localparam cfg_index_t SPARE_INDEX_LO = 3'd5;   // no register behind these
  localparam cfg_index_t SPARE_INDEX_HI = 3'd7;
  localparam cfg_data_t  GAIN_ONE       = 16'h0100;
  localparam cfg_data_t  WORD_MAX       = 16'h7fff;
  localparam cfg_data_t  WORD_MIN       = 16'h8000;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

  // one line of the directed table
  typedef struct {
    row_kind_t  kind;
    cfg_index_t reg_idx;
    cfg_data_t  data;
    sample_t    pos;
    sample_t    vel;
    bit         known;   // drive typed in by hand
    drive_t     want;
  } stim_row_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst;
  always #(PERIOD / 2) clk = ~clk;

  // dut ports
  logic       in_valid;
  logic       in_stall;
  sample_t    position;
  sample_t    velocity;
  logic       out_valid;
  logic       out_stall;
  drive_t     drive;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;

  multi_mode_pd_controller dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .position  (position),
    .velocity  (velocity),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // controller copy kept by the bench: registers and loop state
  mode_t  ctl_mode;
  gain_t  ctl_setpoint;
  gain_t  ctl_gain_p;
  gain_t  ctl_gain_i;
  gain_t  ctl_gain_d;
  err_t   last_error;
  diff_t  aux_reg;       // last first difference (mode 2) or last sign (mode 3)

  drive_t    expected_drive[$];
  stim_row_t stim_rows[$];

  int           mismatches     = 0;
  int           drives_checked = 0;
  int           samples_sent   = 0;
  int           reg_writes     = 0;
  int           cycle_count    = 0;
  logic [3:0]   mode_seen      = '0;
  bit           offering       = 1'b0;
  bit           cfg_active     = 1'b0;
  bit           no_gaps        = 1'b0;
  bit           long_hold_req  = 1'b0;
  int           burst_left     = 0;
  stall_style_t stall_style    = STALL_NONE;

  // --------------------------------------------------------------------------
  // control law, one call per accepted sample, updates the loop state
  // --------------------------------------------------------------------------
  function automatic drive_t control_law(sample_t pos_in, sample_t vel_in);
    longint pos, e, d, a, s, mag, acc;
    pos = pos_in;
    a   = 0;
    if (ctl_mode == MODE_EXT_DERIV) begin
      // error flips sign, derivative comes from the velocity sample
      e = longint'(ctl_setpoint) - pos;
      d = vel_in;
      last_error = e[ERR_W-1:0];
    end else begin
      if (ctl_mode == MODE_SIGN_MAG) begin
        // zero counts as negative; double when the sign moved
        s   = (pos > 0) ? 1 : -1;
        mag = (s == longint'(aux_reg)) ? pos : 2 * pos;
        if (mag < 0) mag = -mag;
        aux_reg = s[DIFF_W-1:0];
        e = mag - ctl_setpoint;
      end else begin
        e = pos - ctl_setpoint;
      end
      d = e - longint'(last_error);
      last_error = e[ERR_W-1:0];
      if (ctl_mode == MODE_SECOND_DIFF) begin
        // aux holds whatever the other mode left there
        a = d - longint'(aux_reg);
        aux_reg = d[DIFF_W-1:0];
      end
    end
    acc = ctl_gain_p * e + ctl_gain_d * d;
    if (ctl_mode == MODE_SECOND_DIFF) acc += ctl_gain_i * a;
    return acc[DRIVE_W-1:0];
  endfunction

  function automatic void apply_write(cfg_index_t idx, cfg_data_t data);
    case (idx)
      REG_MODE:     ctl_mode     = mode_t'(data[1:0]);
      REG_SETPOINT: ctl_setpoint = data;
      REG_GAIN_P:   ctl_gain_p   = data;
      REG_GAIN_I:   ctl_gain_i   = data;
      REG_GAIN_D:   ctl_gain_d   = data;
      default: ;  // spare index, nothing changes
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // random values, extremes and near-zero values weighted up
  // --------------------------------------------------------------------------
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return sample_t'(WORD_MAX);
      1: return sample_t'(WORD_MIN);
      2: return sample_t'($urandom_range(0, 8)) - sample_t'(4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic cfg_data_t pick_gain();
    case ($urandom_range(0, 7))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return GAIN_ONE;
      3: return cfg_data_t'($urandom_range(0, 1023)) - cfg_data_t'(512);
      default: return cfg_data_t'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // directed table builders
  // --------------------------------------------------------------------------
  function automatic void add_write(cfg_index_t idx, cfg_data_t data);
    stim_row_t row;
    row = '{ROW_WRITE, idx, data, '0, '0, 1'b0, '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_sample(sample_t p, sample_t v);
    stim_row_t row;
    row = '{ROW_SAMPLE, '0, '0, p, v, 1'b0, '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_known(sample_t p, sample_t v, longint want);
    stim_row_t row;
    row = '{ROW_SAMPLE, '0, '0, p, v, 1'b1, want[DRIVE_W-1:0]};
    stim_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // sample sender: payload and valid move together, valid held while stalled
  // --------------------------------------------------------------------------
  task automatic offer(sample_t p, sample_t v, bit known, drive_t want);
    drive_t predicted;
    position <= p;
    velocity <= v;
    in_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    // transfer at this edge
    mode_seen[ctl_mode] = 1'b1;
    predicted = control_law(p, v);
    expected_drive.push_back(known ? want : predicted);
    samples_sent++;
  endtask

  task automatic stop_offering();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // bursts of random length, gaps of random length between them
  task automatic pace();
    int gap;
    if (no_gaps) return;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        stop_offering();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_for_results();
    while (expected_drive.size() != 0) @(posedge clk);
  endtask

  // register write, valid left high for a following write of the group
  task automatic write_reg(cfg_index_t idx, cfg_data_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_active = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_write(idx, data);
    reg_writes++;
  endtask

  task automatic cfg_done();
    if (cfg_active) begin
      cfg_valid <= 1'b0;
      cfg_active = 1'b0;
    end
  endtask

  // new settings for a random phase; mode always rewritten
  task automatic random_settings();
    cfg_data_t mode_word;
    mode_word = ($urandom_range(0, 1) == 0) ? cfg_data_t'($urandom) : '0;
    mode_word[1:0] = 2'($urandom_range(0, 3));
    write_reg(REG_MODE, mode_word);
    if ($urandom_range(0, 1) == 0) write_reg(REG_SETPOINT, cfg_data_t'(pick_sample()));
    if ($urandom_range(0, 1) == 0) write_reg(REG_GAIN_P, pick_gain());
    if ($urandom_range(0, 1) == 0) write_reg(REG_GAIN_I, pick_gain());
    if ($urandom_range(0, 1) == 0) write_reg(REG_GAIN_D, pick_gain());
    if ($urandom_range(0, 3) == 0)
      write_reg(cfg_index_t'($urandom_range(SPARE_INDEX_LO, SPARE_INDEX_HI)),
                cfg_data_t'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // result checker, outputs sampled at the edge before they move
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    drive_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_drive.size() == 0) begin
        $error("drive: no result expected, got %0d", drive);
        mismatches++;
      end else begin
        want = expected_drive.pop_front();
        drives_checked++;
        if (drive !== want) begin
          $error("drive: expected %0d, got %0d", want, drive);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: own stall pattern per phase, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int tick;
    hold_left = 0;
    tick      = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (stall_style)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 1) == 0);
          STALL_PERIODIC: out_stall <= ((tick % 7) < 3);
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_multi_mode_pd_controller NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    int count;
    int pause_at;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    position  <= '0;
    velocity  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;

    // reset values of the controller copy
    ctl_mode     = MODE_PD;
    ctl_setpoint = '0;
    ctl_gain_p   = gain_t'(GAIN_ONE);
    ctl_gain_i   = '0;
    ctl_gain_d   = '0;
    last_error   = '0;
    aux_reg      = '0;

    // directed table
    // reset gains: unity p, no d, so drive is 256 times the error
    add_known(16'sd0, 16'sd0, 0);
    add_known(16'sh7fff, -16'sd1, 8388352);
    add_known(sample_t'(WORD_MIN), 16'sh7fff, -8388608);
    // most negative gain on the widest mode-0 error
    add_write(REG_GAIN_P, WORD_MIN);
    add_write(REG_SETPOINT, WORD_MAX);
    add_known(sample_t'(WORD_MIN), 16'sd0, 2147450880);
    add_known(16'sh7fff, 16'sd0, 0);
    // all gains in, second difference
    add_write(REG_GAIN_D, WORD_MAX);
    add_write(REG_GAIN_I, WORD_MIN);
    add_write(REG_MODE, cfg_data_t'(MODE_SECOND_DIFF));
    add_sample(sample_t'(WORD_MIN), sample_t'(WORD_MIN));
    add_sample(16'sh7fff, 16'sd0);
    add_sample(16'sh7fff, 16'sd0);            // zero difference leaves aux at 0
    // sign-magnitude: aux 0 matches no sign, so the first sample doubles
    add_write(REG_MODE, cfg_data_t'(MODE_SIGN_MAG));
    add_sample(sample_t'(WORD_MIN), 16'sd0);
    add_sample(16'sd0, 16'sd0);               // zero counts as negative
    add_sample(16'sh7fff, 16'sd0);            // sign flip, doubled
    add_write(REG_SETPOINT, WORD_MIN);
    add_sample(16'sd1, 16'sd0);
    // external derivative, velocity at both ends
    add_write(REG_MODE, cfg_data_t'(MODE_EXT_DERIV));
    add_sample(sample_t'(WORD_MIN), 16'sh7fff);
    add_sample(16'sh7fff, sample_t'(WORD_MIN));
    // spare indexes change nothing
    add_write(SPARE_INDEX_LO, WORD_MAX);
    add_write(SPARE_INDEX_HI, 16'hffff);
    add_sample(16'sd100, 16'sd5);

    repeat (RESET_TICKS) @(posedge clk);
    rst <= 1'b0;

    stall_style = STALL_LIGHT;
    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_WRITE) begin
        // registers only move with nothing in flight
        stop_offering();
        wait_for_results();
        write_reg(stim_rows[r].reg_idx, stim_rows[r].data);
      end else begin
        cfg_done();
        offer(stim_rows[r].pos, stim_rows[r].vel, stim_rows[r].known, stim_rows[r].want);
        pace();
      end
    end
    cfg_done();

    // random phases, each with its own settings and stall pattern
    phase = 0;
    while (samples_sent < ITEM_TARGET + stim_rows.size()) begin
      stop_offering();
      wait_for_results();
      random_settings();
      cfg_done();
      stall_style = stall_style_t'($urandom_range(0, 3));
      // one phase keeps offering back to back behind a long receiver hold
      no_gaps = (phase == 2);
      if (phase == 2) long_hold_req = 1'b1;
      count    = (phase == 2) ? 40 : $urandom_range(6, 45);
      // one phase stops halfway until the pipeline has emptied
      pause_at = (phase == 4) ? count / 2 : -1;
      for (int k = 0; k < count; k++) begin
        offer(pick_sample(), pick_sample(), 1'b0, '0);
        if (k == pause_at) begin
          stop_offering();
          wait_for_results();
        end else begin
          pace();
        end
      end
      phase++;
    end

    // drain, then watch for stray results
    no_gaps = 1'b0;
    stop_offering();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d samples in %0d phases, %0d register writes, modes seen %b",
             samples_sent, phase, reg_writes, mode_seen);
    $display("%0d drive values checked, %0d mismatches", drives_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_multi_mode_pd_controller OK");
    end else begin
      $display("tb_multi_mode_pd_controller NOT OK");
    end
    $finish;
  end

endmodule
